FILE: hw/rtl/static_arithmetic_decoder_macros.svh
// Assertion helpers for the static arithmetic decoder.
`ifndef STATIC_ARITHMETIC_DECODER_MACROS_SVH
`define STATIC_ARITHMETIC_DECODER_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define SAD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("static_arithmetic_decoder: check failed");

// Next-cycle implication.
`define SAD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("static_arithmetic_decoder: check failed");

`endif

FILE: hw/rtl/sad_pkg.sv
package sad_pkg;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 40;
	localparam int COUNT_W     = 16;
	localparam int CUM_W       = 24;
	localparam int BCNT_W      = 7;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_START  = 2'd1,
		OP_PUSH   = 2'd2,
		OP_DECODE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_MISMATCH    = 3'd1,
		ST_NEED_BITS   = 3'd2,
		ST_ALL_DONE    = 3'd3,
		ST_NOT_STARTED = 3'd4,
		ST_FULL        = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SWEEP_RD,
		S_SWEEP_ADD,
		S_START_CHK,
		S_PRIME,
		S_MUL,
		S_DIV_INIT,
		S_DIV,
		S_DIV_END,
		S_SEARCH,
		S_SEARCH_CMP,
		S_FETCH_LO,
		S_FETCH_HI,
		S_RENORM,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		DSEL_VALUE,
		DSEL_HIGH,
		DSEL_LOW
	} dsel_t;

endpackage

FILE: hw/rtl/static_arithmetic_decoder.sv
// Channel | Signals                                  | Item
// in      | s_axis_tvalid/tready/tdata/tuser/tlast   | operation, index, count, byte, last
// out     | m_axis_tvalid/tready/tdata/tuser         | one result for every input item
//
// A start item sweeps the count table, reading and adding one symbol at a
// time. A decode item runs the shared restoring divider for three CODE_BITS+17
// step divisions, then renormalizes; the first decode of a stream also primes
// the code window from the buffer. arst_n clears all control and range state;
// the tables hold garbage until loaded. A stalled output holds the block
// in its finish state; the input is ready only when idle.
module static_arithmetic_decoder #(
	parameter int SYMBOL_COUNT = 256,
	parameter int CODE_BITS    = 32,
	parameter int BUFFER_BITS  = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// table_index[7:0], count_value[23:8], code_byte[31:24]
	input  logic [sad_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// operation[1:0]
	input  logic [sad_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input  logic                            s_axis_tlast,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// symbol[7:0], status[10:8], symbols_left[26:11], buffered_bits[33:27], zero[39:34]
	output logic [sad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// symbol_valid[0]
	output logic                            m_axis_tuser
);
	import sad_pkg::*;

	localparam int CW  = CODE_BITS;
	localparam int RW  = CW + 1;
	localparam int NW  = RW + COUNT_W;
	localparam int SW  = $clog2(SYMBOL_COUNT);
	localparam int BIW = $clog2(BUFFER_BITS);
	localparam int PW  = $clog2(CODE_BITS + 1);
	localparam int DCW = $clog2(NW);
	localparam int RCW = $clog2(CODE_BITS + 2);
	localparam logic [CW-1:0] HALF    = CW'(1) << (CW - 1);
	localparam logic [CW-1:0] QUARTER = CW'(1) << (CW - 2);
	localparam logic [CW-1:0] THREEQ  = HALF + QUARTER;

	// Input fields
	logic                 in_acc;
	op_t                  in_op;
	logic [7:0]           in_index;
	logic [COUNT_W-1:0]   in_count;
	logic [7:0]           in_byte;

	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign in_op    = op_t'(s_axis_tuser);
	assign in_index = s_axis_tdata[7:0];
	assign in_count = s_axis_tdata[23:8];
	assign in_byte  = s_axis_tdata[31:24];

	state_t state_q, state_d;

	// Stream state
	logic [CW-1:0]          low_q, high_q, code_q;
	logic [COUNT_W-1:0]     total_q, remain_q, expect_q;
	logic [BUFFER_BITS-1:0] buf_q;
	logic [BCNT_W-1:0]      bcnt_q;
	logic [PW-1:0]          primed_q;
	logic                   ended_q, started_q;

	// Tables
	logic [COUNT_W-1:0] count_mem [SYMBOL_COUNT];
	logic [CUM_W-1:0]   cum_mem [SYMBOL_COUNT];
	logic [COUNT_W-1:0] cnt_rd_q;
	logic [CUM_W-1:0]   cum_rd_q;
	logic [SW-1:0]      cum_raddr;
	logic               cnt_we, cum_we;

	// Sequencer datapath
	logic [SW:0]        sweep_q;
	logic [CUM_W-1:0]   run_q;
	logic [RW-1:0]      range_q, divisor_q, rem_q;
	logic [NW-1:0]      prod_q, quo_q;
	logic [DCW-1:0]     div_cnt_q;
	dsel_t              dsel_q;
	logic [COUNT_W-1:0] value_q, slo_q, shi_q;
	logic [SW:0]        lo_q, hi_q, mid_q, mid_d;
	logic [SW-1:0]      s_q;
	logic [RCW-1:0]     ren_cnt_q;

	// Result being built
	logic [7:0] res_sym_q;
	logic       res_valid_q;
	status_t    res_status_q;

	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_tuser_q, m_tvalid_q;

	// Bit take from the buffer, shared by priming and renormalization
	logic          has_bit, tb_bit;
	logic [BIW-1:0] bidx;
	assign has_bit = (bcnt_q != '0);
	assign bidx    = BIW'(bcnt_q - BCNT_W'(1));
	assign tb_bit  = has_bit ? buf_q[bidx] : 1'b0;

	logic push_full, load_ok;
	assign push_full = ({1'b0, bcnt_q} + 8'd8) > 8'(BUFFER_BITS);
	assign load_ok   = {1'b0, in_index} < 9'(SYMBOL_COUNT);

	logic prime_step, need_bits;
	assign prime_step = (primed_q < PW'(CW)) && (has_bit || ended_q);
	assign need_bits  = (primed_q < PW'(CW)) || ((bcnt_q < BCNT_W'(CW)) && !ended_q);

	// Shared multiplier
	logic [RW-1:0]      mul_a;
	logic [COUNT_W-1:0] mul_b;
	logic [NW-1:0]      prod_d;
	always_comb begin
		case (dsel_q)
			DSEL_VALUE: begin
				mul_a = {1'b0, code_q - low_q} + RW'(1);
				mul_b = total_q;
			end
			DSEL_HIGH: begin
				mul_a = range_q;
				mul_b = shi_q;
			end
			default: begin
				mul_a = range_q;
				mul_b = slo_q;
			end
		endcase
		prod_d = NW'(mul_a) * NW'(mul_b);
	end

	// Shared restoring divider step
	logic [RW:0]   trial;
	logic          trial_ge;
	logic [RW:0]   trial_sub;
	assign trial     = {rem_q, quo_q[NW-1]};
	assign trial_ge  = trial >= {1'b0, divisor_q};
	assign trial_sub = trial - {1'b0, divisor_q};

	// Renormalization decision
	logic          rn_e1, rn_e2, rn_e3, rn_act;
	logic [CW-1:0] rn_sub;
	assign rn_e1  = high_q < HALF;
	assign rn_e2  = low_q >= HALF;
	assign rn_e3  = (low_q >= QUARTER) && (high_q < THREEQ);
	assign rn_act = (rn_e1 || rn_e2 || rn_e3) && (ren_cnt_q <= RCW'(CW));
	assign rn_sub = rn_e1 ? '0 : (rn_e2 ? HALF : QUARTER);

	assign mid_d = (lo_q + hi_q) >> 1;

	always_comb begin
		cum_raddr = mid_d[SW-1:0];
		case (state_q)
			S_SEARCH:   cum_raddr = (lo_q + 1'b1 < hi_q) ? mid_d[SW-1:0] : lo_q[SW-1:0];
			S_FETCH_LO: cum_raddr = s_q + SW'(1);
			default:    cum_raddr = mid_d[SW-1:0];
		endcase
	end

	assign cnt_we = in_acc && (in_op == OP_LOAD) && load_ok;
	assign cum_we = (state_q == S_SWEEP_RD);

	// Table memories
	always_ff @(posedge clk) begin
		if (cnt_we) begin
			count_mem[in_index[SW-1:0]] <= in_count;
		end
		cnt_rd_q <= count_mem[sweep_q[SW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cum_we) begin
			cum_mem[sweep_q[SW-1:0]] <= run_q;
		end
		cum_rd_q <= cum_mem[cum_raddr];
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (in_op == OP_START) begin
						state_d = S_SWEEP_RD;
					end else if (in_op == OP_DECODE && started_q && remain_q != '0) begin
						state_d = S_PRIME;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_SWEEP_RD:  state_d = S_SWEEP_ADD;
			S_SWEEP_ADD: state_d = (sweep_q == (SW+1)'(SYMBOL_COUNT - 1)) ? S_START_CHK
				: S_SWEEP_RD;
			S_START_CHK: state_d = S_FINISH;
			S_PRIME: begin
				if (!prime_step) begin
					state_d = need_bits ? S_FINISH : S_MUL;
				end
			end
			S_MUL:      state_d = S_DIV_INIT;
			S_DIV_INIT: state_d = S_DIV;
			S_DIV:      state_d = (div_cnt_q == DCW'(NW - 1)) ? S_DIV_END : S_DIV;
			S_DIV_END: begin
				case (dsel_q)
					DSEL_VALUE: state_d = S_SEARCH;
					DSEL_HIGH:  state_d = S_MUL;
					default:    state_d = S_RENORM;
				endcase
			end
			S_SEARCH:     state_d = (lo_q + 1'b1 < hi_q) ? S_SEARCH_CMP : S_FETCH_LO;
			S_SEARCH_CMP: state_d = S_SEARCH;
			S_FETCH_LO:   state_d = S_FETCH_HI;
			S_FETCH_HI:   state_d = S_MUL;
			S_RENORM:     state_d = rn_act ? S_RENORM : S_FINISH;
			S_FINISH:     state_d = (!m_tvalid_q || m_axis_tready) ? S_IDLE : S_FINISH;
			default:      state_d = S_IDLE;
		endcase
	end

	// Control and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q       <= '0;
			high_q      <= '1;
			code_q      <= '0;
			total_q     <= '0;
			remain_q    <= '0;
			buf_q       <= '0;
			bcnt_q      <= '0;
			primed_q    <= '0;
			ended_q     <= 1'b0;
			started_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && in_op == OP_START) begin
						// Drop any buffered bytes and reopen the full range
						low_q    <= '0;
						high_q   <= '1;
						code_q   <= '0;
						buf_q    <= '0;
						bcnt_q   <= '0;
						primed_q <= '0;
						ended_q  <= 1'b0;
					end else if (in_acc && in_op == OP_PUSH && !push_full) begin
						buf_q  <= {buf_q[BUFFER_BITS-9:0], in_byte};
						bcnt_q <= bcnt_q + BCNT_W'(8);
						if (s_axis_tlast) begin
							ended_q <= 1'b1;
						end
					end
				end
				S_START_CHK: begin
					if (run_q != CUM_W'(expect_q)) begin
						started_q <= 1'b0;
						remain_q  <= '0;
						total_q   <= '0;
					end else begin
						started_q <= 1'b1;
						total_q   <= expect_q;
						remain_q  <= expect_q;
					end
				end
				S_PRIME: begin
					if (prime_step) begin
						code_q   <= {code_q[CW-2:0], tb_bit};
						primed_q <= primed_q + PW'(1);
						if (has_bit) begin
							bcnt_q <= bcnt_q - BCNT_W'(1);
						end
					end
				end
				S_DIV_END: begin
					if (dsel_q == DSEL_HIGH) begin
						high_q <= low_q + quo_q[CW-1:0] - CW'(1);
					end else if (dsel_q == DSEL_LOW) begin
						low_q <= low_q + quo_q[CW-1:0];
					end
				end
				S_RENORM: begin
					if (rn_act) begin
						low_q  <= CW'({low_q - rn_sub, 1'b0});
						high_q <= CW'({high_q - rn_sub, 1'b1});
						code_q <= CW'({code_q - rn_sub, tb_bit});
						if (has_bit) begin
							bcnt_q <= bcnt_q - BCNT_W'(1);
						end
					end else begin
						remain_q <= remain_q - COUNT_W'(1);
					end
				end
				S_FINISH: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Sequencer datapath and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				res_sym_q    <= '0;
				res_valid_q  <= 1'b0;
				res_status_q <= ST_OK;
				sweep_q      <= '0;
				run_q        <= '0;
				expect_q     <= in_count;
				if (in_acc && in_op == OP_PUSH && push_full) begin
					res_status_q <= ST_FULL;
				end else if (in_acc && in_op == OP_DECODE) begin
					if (!started_q) begin
						res_status_q <= ST_NOT_STARTED;
					end else if (remain_q == '0) begin
						res_status_q <= ST_ALL_DONE;
					end
				end
			end
			S_SWEEP_ADD: begin
				run_q   <= run_q + CUM_W'(cnt_rd_q);
				sweep_q <= sweep_q + 1'b1;
			end
			S_START_CHK: begin
				if (run_q != CUM_W'(expect_q)) begin
					res_status_q <= ST_MISMATCH;
				end
			end
			S_PRIME: begin
				dsel_q  <= DSEL_VALUE;
				range_q <= {1'b0, high_q - low_q} + RW'(1);
				if (!prime_step && need_bits) begin
					res_status_q <= ST_NEED_BITS;
				end
			end
			S_MUL: begin
				prod_q <= prod_d;
			end
			S_DIV_INIT: begin
				quo_q     <= prod_q - NW'(dsel_q == DSEL_VALUE);
				rem_q     <= '0;
				div_cnt_q <= '0;
				divisor_q <= (dsel_q == DSEL_VALUE) ? range_q : RW'(total_q);
			end
			S_DIV: begin
				quo_q     <= {quo_q[NW-2:0], trial_ge};
				rem_q     <= trial_ge ? trial_sub[RW-1:0] : trial[RW-1:0];
				div_cnt_q <= div_cnt_q + DCW'(1);
			end
			S_DIV_END: begin
				if (dsel_q == DSEL_VALUE) begin
					// Clamp so the chosen symbol always has a nonzero count
					value_q <= (quo_q >= NW'(total_q)) ? total_q - COUNT_W'(1)
						: quo_q[COUNT_W-1:0];
					lo_q <= '0;
					hi_q <= (SW+1)'(SYMBOL_COUNT);
				end else if (dsel_q == DSEL_HIGH) begin
					dsel_q <= DSEL_LOW;
				end
				ren_cnt_q <= '0;
			end
			S_SEARCH: begin
				mid_q <= mid_d;
				s_q   <= lo_q[SW-1:0];
			end
			S_SEARCH_CMP: begin
				if (cum_rd_q <= CUM_W'(value_q)) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			S_FETCH_LO: begin
				slo_q <= cum_rd_q[COUNT_W-1:0];
			end
			S_FETCH_HI: begin
				shi_q  <= ({1'b0, s_q} == (SW+1)'(SYMBOL_COUNT - 1)) ? total_q
					: cum_rd_q[COUNT_W-1:0];
				dsel_q <= DSEL_HIGH;
			end
			S_RENORM: begin
				if (rn_act) begin
					ren_cnt_q <= ren_cnt_q + RCW'(1);
				end else begin
					res_sym_q   <= 8'(s_q);
					res_valid_q <= 1'b1;
				end
			end
			S_FINISH: begin
				if (!m_tvalid_q || m_axis_tready) begin
					m_tdata_q <= {6'd0, bcnt_q, remain_q, res_status_q, res_sym_q};
					m_tuser_q <= res_valid_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;
	assign m_axis_tuser  = m_tuser_q;

endmodule

FILE: hw/rtl/sad_checker.sv
`include "static_arithmetic_decoder_macros.svh"

module sad_checker #(
	parameter int BUFFER_BITS = 64
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic [sad_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tuser
);
	import sad_pkg::*;

	// A decoded symbol always comes with an ok status
	`SAD_ASSERT_IMPL(a_valid_ok, m_axis_tvalid && m_axis_tuser, m_axis_tdata[10:8] == ST_OK)
	// No symbol value without a decode
	`SAD_ASSERT_IMPL(a_sym_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[7:0] == 8'd0)
	// The bit buffer never overfills
	`SAD_ASSERT_IMPL(a_buf_cap, m_axis_tvalid, m_axis_tdata[33:27] <= 7'(BUFFER_BITS))
	// Work on one item at a time
	`SAD_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind static_arithmetic_decoder sad_checker #(.BUFFER_BITS(BUFFER_BITS)) u_sad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: tb/tb_static_arithmetic_decoder.sv
`timescale 1ns / 100ps

module tb_static_arithmetic_decoder;
	import sad_pkg::*;

	localparam int           NSYM        = 256;
	localparam int           NBITS_CODE  = 32;
	localparam int           NBITS_BUF   = 64;
	localparam logic [63:0]  CMASK       = 64'hFFFF_FFFF;
	localparam logic [63:0]  HALF        = 64'h8000_0000;
	localparam logic [63:0]  QUARTER     = 64'h4000_0000;
	localparam logic [63:0]  THREE_Q     = 64'hC000_0000;
	localparam int           ITEM_TARGET = 1500;
	localparam longint       CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [7:0]  symbol;
		logic        valid;
		status_t     status;
		logic [15:0] left;
		logic [6:0]  bits;
	} result_t;

	typedef struct {
		op_t         op;
		logic [7:0]  idx;
		logic [15:0] cnt;
		logic [7:0]  code;
		logic        last;
		bit          typed;
		result_t     res;
	} row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata;
	logic [IN_TUSER_W-1:0] s_axis_tuser;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;

	// shadow decoder state
	logic [15:0] freq_tab[NSYM];
	logic [31:0] cum_tab[NSYM];
	logic [63:0] rng_low, rng_high, code_win, bit_buf;
	int unsigned freq_total, syms_left, buf_count, primed;
	bit ended, started;

	result_t     pending_results[$];
	int          fail_count;
	int          sent_items;
	int          seen_results;
	longint      cycles;
	bit          hold_off;

	static_arithmetic_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// free-running cycle count with a hard stop
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("FAIL static_arithmetic_decoder");
				$finish;
			end
		end
	end

	function automatic logic [63:0] cum_at(int unsigned i);
		if (i >= NSYM)
			return 64'(freq_total);
		return 64'(cum_tab[i]);
	endfunction

	// pull one code bit, MSB first; empty buffer reads as zero
	function automatic logic [63:0] pull_bit();
		logic [63:0] b;
		if (buf_count == 0)
			return 64'd0;
		buf_count--;
		b = (bit_buf >> buf_count) & 64'd1;
		bit_buf &= (64'd1 << buf_count) - 64'd1;
		return b;
	endfunction

	function automatic void clear_stream();
		rng_low = 64'd0;
		rng_high = CMASK;
		code_win = 64'd0;
		bit_buf = 64'd0;
		buf_count = 0;
		primed = 0;
		ended = 1'b0;
	endfunction

	// predict the result of one item and advance the shadow state
	function automatic result_t predict_decode(op_t op, logic [7:0] idx, logic [15:0] cnt,
						   logic [7:0] code, logic last);
		result_t     r;
		int unsigned run, lo, hi, mid, s;
		logic [63:0] total, width, offs, value, s_lo, s_hi;
		r.symbol = 8'd0;
		r.valid = 1'b0;
		r.status = ST_OK;
		case (op)
		OP_LOAD: begin
			freq_tab[idx] = cnt;
		end
		OP_START: begin
			run = 0;
			clear_stream();
			for (int i = 0; i < NSYM; i++) begin
				cum_tab[i] = run;
				run += freq_tab[i];
			end
			if (run != cnt) begin
				r.status = ST_MISMATCH;
				started = 1'b0;
				syms_left = 0;
				freq_total = 0;
			end else begin
				started = 1'b1;
				freq_total = run;
				syms_left = cnt;
			end
		end
		OP_PUSH: begin
			if (buf_count + 8 > NBITS_BUF) begin
				r.status = ST_FULL;
			end else begin
				bit_buf = (bit_buf << 8) | 64'(code);
				buf_count += 8;
				if (last)
					ended = 1'b1;
			end
		end
		default: begin
			if (!started) begin
				r.status = ST_NOT_STARTED;
			end else if (syms_left == 0) begin
				r.status = ST_ALL_DONE;
			end else begin
				while (primed < NBITS_CODE && (buf_count > 0 || ended)) begin
					code_win = ((code_win << 1) & CMASK) | pull_bit();
					primed++;
				end
				if (primed < NBITS_CODE || (buf_count < NBITS_CODE && !ended)) begin
					r.status = ST_NEED_BITS;
				end else begin
					total = 64'(freq_total);
					width = ((rng_high - rng_low) & CMASK) + 64'd1;
					offs = ((code_win - rng_low) & CMASK) + 64'd1;
					value = (offs * total - 64'd1) / width;
					if (value >= total)
						value = total - 64'd1;
					lo = 0;
					hi = NSYM;
					while (lo + 1 < hi) begin
						mid = (lo + hi) / 2;
						if (cum_at(mid) <= value)
							lo = mid;
						else
							hi = mid;
					end
					s = lo;
					s_lo = cum_at(s);
					s_hi = cum_at(s + 1);
					rng_high = (rng_low + (width * s_hi) / total - 64'd1) & CMASK;
					rng_low = (rng_low + (width * s_lo) / total) & CMASK;
					for (int n = 0; n <= NBITS_CODE; n++) begin
						if (rng_high < HALF) begin
							// low half: plain shift
						end else if (rng_low >= HALF) begin
							rng_low -= HALF;
							rng_high -= HALF;
							code_win = (code_win - HALF) & CMASK;
						end else if (rng_low >= QUARTER && rng_high < THREE_Q) begin
							rng_low -= QUARTER;
							rng_high -= QUARTER;
							code_win = (code_win - QUARTER) & CMASK;
						end else begin
							break;
						end
						rng_low = (rng_low << 1) & CMASK;
						rng_high = ((rng_high << 1) & CMASK) | 64'd1;
						code_win = ((code_win << 1) & CMASK) | pull_bit();
					end
					syms_left = (syms_left - 1) & 32'hFFFF;
					r.symbol = s[7:0];
					r.valid = 1'b1;
				end
			end
		end
		endcase
		r.left = syms_left[15:0];
		r.bits = buf_count[6:0];
		return r;
	endfunction

	// offer one item after a random gap and hold it until accepted;
	// the shadow model advances at the accepting edge
	task automatic send_item(op_t op, logic [7:0] idx, logic [15:0] cnt, logic [7:0] code,
				 logic last, bit typed, result_t typed_res);
		int      gap;
		result_t r;
		gap = $urandom_range(0, 18);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {code, cnt, idx};
		s_axis_tuser = op;
		s_axis_tlast = last;
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = predict_decode(op, idx, cnt, code, last);
		if (typed && r != typed_res) begin
			// a typed row disagreeing with the shadow model is a bench bug; flag it
			$display("%0t: table row disagrees with shadow model (op %s)", $time, op.name());
			fail_count++;
		end
		pending_results.push_back(typed ? typed_res : r);
		sent_items++;
		@(negedge clk);
	endtask

	function automatic result_t res(logic [7:0] sym, logic v, status_t st, logic [15:0] left,
					logic [6:0] bits);
		result_t r;
		r.symbol = sym;
		r.valid = v;
		r.status = st;
		r.left = left;
		r.bits = bits;
		return r;
	endfunction

	// receiver: random stall per result, plus one long hold-off
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_off || stall > 0) begin
				m_axis_tready = 1'b0;
				if (stall > 0)
					stall--;
			end else begin
				m_axis_tready = 1'b1;
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
			end
		end
	end

	// long hold-off: the block sits in finish and stalls its input
	initial begin
		hold_off = 1'b0;
		wait (seen_results >= 300);
		hold_off = 1'b1;
		repeat (600) @(posedge clk);
		hold_off = 1'b0;
	end

	// compare each accepted result with the oldest prediction
	initial begin
		result_t want, got;
		seen_results = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.symbol = m_axis_tdata[7:0];
				got.valid = m_axis_tuser;
				got.status = status_t'(m_axis_tdata[10:8]);
				got.left = m_axis_tdata[26:11];
				got.bits = m_axis_tdata[33:27];
				seen_results++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, got sym %0d valid %0d st %0d",
						 $time, got.symbol, got.valid, got.status);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.symbol !== want.symbol) begin
						$display("%0t: symbol exp %0d got %0d", $time, want.symbol, got.symbol);
						fail_count++;
					end
					if (got.valid !== want.valid) begin
						$display("%0t: symbol_valid exp %0d got %0d", $time, want.valid,
							 got.valid);
						fail_count++;
					end
					if (got.status !== want.status) begin
						$display("%0t: status exp %0d got %0d", $time, want.status,
							 got.status);
						fail_count++;
					end
					if (got.left !== want.left) begin
						$display("%0t: symbols_left exp %0d got %0d", $time, want.left,
							 got.left);
						fail_count++;
					end
					if (got.bits !== want.bits) begin
						$display("%0t: buffered_bits exp %0d got %0d", $time, want.bits,
							 got.bits);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		row_t        dir_rows[$];
		result_t     none;
		int unsigned sum, n_ops, k, sel;
		logic [7:0]  used_idx[$];
		logic [7:0]  ix;
		logic [15:0] cv;

		// drive every input known from time zero
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_LOAD;
		s_axis_tlast = 1'b0;
		fail_count = 0;
		sent_items = 0;
		none = res(8'd0, 1'b0, ST_OK, 16'd0, 7'd0);
		for (int i = 0; i < NSYM; i++) begin
			freq_tab[i] = 16'd0;
			cum_tab[i] = 32'd0;
		end
		clear_stream();
		freq_total = 0;
		syms_left = 0;
		started = 1'b0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: typed results where they follow at a glance
		dir_rows = '{
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 1, res(0, 0, ST_NOT_STARTED, 0, 0)},
			'{OP_PUSH,   8'd0,   16'd0,     8'hFF, 1'b0, 1, res(0, 0, ST_OK, 0, 8)},
			'{OP_LOAD,   8'd255, 16'hFFFF,  8'h00, 1'b0, 1, res(0, 0, ST_OK, 0, 8)},
			'{OP_START,  8'd0,   16'd0,     8'h00, 1'b0, 1, res(0, 0, ST_MISMATCH, 0, 0)},
			'{OP_LOAD,   8'd255, 16'd0,     8'h00, 1'b0, 0, none},
			'{OP_LOAD,   8'd0,   16'd3,     8'h00, 1'b0, 0, none},
			'{OP_LOAD,   8'd200, 16'd5,     8'h00, 1'b0, 0, none},
			'{OP_START,  8'd0,   16'd8,     8'h00, 1'b0, 1, res(0, 0, ST_OK, 8, 0)},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 1, res(0, 0, ST_NEED_BITS, 8, 0)},
			'{OP_PUSH,   8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_PUSH,   8'd0,   16'd0,     8'hA5, 1'b0, 0, none},
			'{OP_PUSH,   8'd0,   16'd0,     8'h5A, 1'b0, 0, none},
			'{OP_PUSH,   8'd0,   16'd0,     8'hFF, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_PUSH,   8'd0,   16'd0,     8'h3C, 1'b1, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 0, none},
			'{OP_DECODE, 8'd0,   16'd0,     8'h00, 1'b0, 1, res(0, 0, ST_ALL_DONE, 0, 0)}
		};

		// the first start sums the whole table, so load every count first
		for (int i = 0; i < NSYM; i++)
			send_item(OP_LOAD, i[7:0], 16'd0, 8'h00, 1'b0, 0, none);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].cnt, dir_rows[i].code,
				  dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);
		used_idx.push_back(8'd0);
		used_idx.push_back(8'd200);

		// random streams: new distribution, start, then pushes and decodes
		while (sent_items < ITEM_TARGET) begin
			// drop the previous distribution
			foreach (used_idx[i])
				send_item(OP_LOAD, used_idx[i], 16'd0, 8'($urandom), 1'($urandom), 0, none);
			used_idx.delete();
			k = $urandom_range(1, 8);
			for (int i = 0; i < k; i++) begin
				ix = 8'($urandom);
				cv = ($urandom_range(0, 15) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
				used_idx.push_back(ix);
				send_item(OP_LOAD, ix, cv, 8'($urandom), 1'($urandom), 0, none);
			end
			sum = 0;
			foreach (freq_tab[i])
				sum += freq_tab[i];
			cv = ($urandom_range(0, 9) == 0) ? 16'($urandom) : sum[15:0];
			send_item(OP_START, 8'($urandom), cv, 8'($urandom), 1'($urandom), 0, none);
			n_ops = $urandom_range(10, 80);
			for (int i = 0; i < n_ops; i++) begin
				sel = $urandom_range(0, 19);
				if (sel < 8) begin
					send_item(OP_PUSH, 8'($urandom), 16'($urandom), 8'($urandom),
						  $urandom_range(0, 11) == 0, 0, none);
				end else if (sel < 19) begin
					send_item(OP_DECODE, 8'($urandom), 16'($urandom), 8'($urandom),
						  1'($urandom), 0, none);
				end else begin
					// noise: a load outside the live distribution or a stray op
					ix = 8'($urandom);
					used_idx.push_back(ix);
					send_item(op_t'($urandom_range(0, 3)) == OP_START ? OP_DECODE : OP_LOAD,
						  ix, 16'($urandom), 8'($urandom), 1'($urandom), 0, none);
				end
			end
		end
		s_axis_tvalid = 1'b0;

		// drain, then let the block settle
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("PASS static_arithmetic_decoder");
		else
			$display("FAIL static_arithmetic_decoder");
		$finish;
	end

endmodule

FILE: static_arithmetic_decoder.f
+incdir+hw/rtl
hw/rtl/sad_pkg.sv
hw/rtl/static_arithmetic_decoder.sv
hw/rtl/sad_checker.sv
tb/tb_static_arithmetic_decoder.sv
